### rtl/glseq_pkg.sv
// Package for the gamepad link sequencer: types, constants and command tables.
package glseq_pkg;

  localparam int unsigned DATA_BYTES_DEF = 6;
  localparam int unsigned MAX_DATA_BYTES = 6;

  localparam logic [7:0] CMD_START   = 8'h01;
  localparam logic [7:0] CMD_ENTER   = 8'h43;
  localparam logic [7:0] CMD_ANALOG  = 8'h44;
  localparam logic [7:0] CMD_POLL    = 8'h42;
  localparam logic [7:0] CMD_EXIT_PAD = 8'h5A;
  localparam logic [7:0] CMD_LOCK    = 8'h03;
  localparam logic [7:0] CMD_IDLE    = 8'h00;
  localparam logic [7:0] ANALOG_ID   = 8'h73;
  localparam logic [7:0] ATTEMPT_MAX = 8'd254;
  localparam logic [7:0] LED_OFF     = 8'hFF;

  localparam logic [4:0] LEN_ENTER   = 5'd5;
  localparam logic [4:0] LEN_SETUP   = 5'd9;
  localparam logic [3:0] POLL_HDR    = 4'd3;

  typedef enum logic [2:0] {
    KIND_ENTER  = 3'd0,
    KIND_ANALOG = 3'd1,
    KIND_EXIT   = 3'd2,
    KIND_CHECK  = 3'd3,
    KIND_POLL   = 3'd4
  } frame_kind_t;

  function automatic logic [7:0] command_at(input frame_kind_t k, input logic [3:0] i);
    logic [7:0] c;
    c = CMD_IDLE;
    case (k)
      KIND_ENTER: begin
        case (i)
          4'd0: c = CMD_START;
          4'd1: c = CMD_ENTER;
          4'd3: c = CMD_START;
          default: c = CMD_IDLE;
        endcase
      end
      KIND_ANALOG: begin
        case (i)
          4'd0: c = CMD_START;
          4'd1: c = CMD_ANALOG;
          4'd3: c = CMD_START;
          4'd4: c = CMD_LOCK;
          default: c = CMD_IDLE;
        endcase
      end
      KIND_EXIT: begin
        case (i)
          4'd0: c = CMD_START;
          4'd1: c = CMD_ENTER;
          4'd4, 4'd5, 4'd6, 4'd7, 4'd8: c = CMD_EXIT_PAD;
          default: c = CMD_IDLE;
        endcase
      end
      default: begin
        case (i)
          4'd0: c = CMD_START;
          4'd1: c = CMD_POLL;
          default: c = CMD_IDLE;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

### rtl/gamepad_link_sequencer_top.sv
// Byte-level host sequencer for a gamepad link: set-up retries, polling, LED select.
// Takes one reply word per cycle unless a result is held waiting for out_ready, and
// gives one result word for each. A reply is captured in an input register; the frame
// sequencing and state update run in a single combinational pass from there into the
// result register, and loading that register raises out_valid. While a finished result waits for
// out_ready the input register can still take one more word; in_ready then stays low
// until the result leaves. After reset the host is taken to have sent the first
// command word (0x01) of the enter-config frame already.
module gamepad_link_sequencer_top #(
  parameter int unsigned DATA_BYTES = glseq_pkg::DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_reply_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_next_command,
  output logic        out_starts_frame,
  output logic        out_ends_frame,
  output logic        out_polling,
  output logic [47:0] out_pad_bytes,
  output logic [7:0]  out_led_pattern_n,
  output logic        out_led_updated
);

  localparam logic [4:0] LEN_POLL = 5'(glseq_pkg::POLL_HDR) + 5'(DATA_BYTES);
  localparam logic [3:0] DB4      = 4'(DATA_BYTES);
  localparam logic [2:0] DB3      = 3'(DATA_BYTES);

  logic                   in_valid_r;
  logic [7:0]             reply_r;
  logic                   out_valid_r;
  logic                   advance;

  glseq_pkg::frame_kind_t frame_kind_r, frame_kind_nxt, kind_cur;
  logic [3:0]             byte_index_r, byte_index_nxt;
  logic [7:0]             attempt_r, attempt_nxt;
  logic [7:0]             mode_reply_r, mode_reply_nxt;
  logic [47:0]            data_r, data_nxt;
  logic [2:0]             shown_r, shown_nxt;
  logic                   armed_r, armed_nxt;
  logic [7:0]             led_r, led_nxt;

  logic [4:0]             flen;
  logic                   frame_end;
  logic [3:0]             pos;
  logic [7:0]             d0;
  logic [7:0]             shown_byte;
  logic                   updated;

  logic [7:0]             cmd_r;
  logic                   end_r;
  logic                   polling_r;
  logic                   upd_r;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    case (frame_kind_r)
      glseq_pkg::KIND_ENTER, glseq_pkg::KIND_ANALOG, glseq_pkg::KIND_EXIT,
      glseq_pkg::KIND_CHECK, glseq_pkg::KIND_POLL: kind_cur = frame_kind_r;
      default: kind_cur = glseq_pkg::KIND_ENTER;
    endcase
  end

  always_comb begin
    case (kind_cur)
      glseq_pkg::KIND_ENTER: flen = glseq_pkg::LEN_ENTER;
      glseq_pkg::KIND_POLL:  flen = LEN_POLL;
      default:               flen = glseq_pkg::LEN_SETUP;
    endcase
  end

  assign frame_end = ({1'b0, byte_index_r} + 5'd1) >= flen;
  assign pos       = byte_index_r - glseq_pkg::POLL_HDR;

  // data capture and mode reply capture
  always_comb begin
    mode_reply_nxt = mode_reply_r;
    if (kind_cur == glseq_pkg::KIND_CHECK && byte_index_r == 4'd1) begin
      mode_reply_nxt = reply_r;
    end
    data_nxt = data_r;
    for (int j = 0; j < glseq_pkg::MAX_DATA_BYTES; j++) begin
      if (kind_cur == glseq_pkg::KIND_POLL && byte_index_r >= glseq_pkg::POLL_HDR &&
          pos < DB4 && pos == 4'(j)) begin
        data_nxt[8*j +: 8] = reply_r;
      end
    end
  end

  assign d0 = data_nxt[7:0];

  // next frame, attempt count and select handling
  always_comb begin
    frame_kind_nxt = kind_cur;
    byte_index_nxt = byte_index_r + 4'd1;
    attempt_nxt    = attempt_r;
    shown_nxt      = shown_r;
    armed_nxt      = armed_r;
    if (frame_end) begin
      byte_index_nxt = 4'd0;
      case (kind_cur)
        glseq_pkg::KIND_CHECK: begin
          attempt_nxt    = (attempt_r >= glseq_pkg::ATTEMPT_MAX) ? 8'd0 : attempt_r + 8'd1;
          frame_kind_nxt = (mode_reply_nxt == glseq_pkg::ANALOG_ID) ?
                           glseq_pkg::KIND_POLL : glseq_pkg::KIND_ENTER;
        end
        glseq_pkg::KIND_POLL: begin
          if (!d0[0] && !armed_r) begin
            armed_nxt = 1'b1;
          end else if (d0[0] && armed_r) begin
            shown_nxt = (shown_r + 3'd1 >= DB3) ? 3'd0 : shown_r + 3'd1;
            armed_nxt = 1'b0;
          end
        end
        glseq_pkg::KIND_ENTER:  frame_kind_nxt = glseq_pkg::KIND_ANALOG;
        glseq_pkg::KIND_ANALOG: frame_kind_nxt = glseq_pkg::KIND_EXIT;
        default:                frame_kind_nxt = glseq_pkg::KIND_CHECK;
      endcase
    end
  end

  always_comb begin
    shown_byte = 8'd0;
    for (int j = 0; j < glseq_pkg::MAX_DATA_BYTES; j++) begin
      if (shown_nxt == 3'(j) && shown_nxt < DB3) begin
        shown_byte = data_nxt[8*j +: 8];
      end
    end
  end

  // LED byte
  always_comb begin
    led_nxt = led_r;
    if (frame_end) begin
      case (kind_cur)
        glseq_pkg::KIND_CHECK: led_nxt = ~attempt_r;
        glseq_pkg::KIND_POLL:  led_nxt = ~shown_byte;
        default:               led_nxt = led_r;
      endcase
    end
    updated = led_nxt != led_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      frame_kind_r <= glseq_pkg::KIND_ENTER;
      byte_index_r <= 4'd0;
      attempt_r    <= 8'd0;
      mode_reply_r <= 8'd0;
      data_r       <= 48'd0;
      shown_r      <= 3'd0;
      armed_r      <= 1'b0;
      led_r        <= glseq_pkg::LED_OFF;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        frame_kind_r <= frame_kind_nxt;
        byte_index_r <= byte_index_nxt;
        attempt_r    <= attempt_nxt;
        mode_reply_r <= mode_reply_nxt;
        data_r       <= data_nxt;
        shown_r      <= shown_nxt;
        armed_r      <= armed_nxt;
        led_r        <= led_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      reply_r <= in_reply_byte;
    end
    if (advance) begin
      cmd_r     <= glseq_pkg::command_at(frame_kind_nxt, byte_index_nxt);
      end_r     <= frame_end;
      polling_r <= frame_kind_nxt == glseq_pkg::KIND_POLL;
      upd_r     <= updated;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_command  = cmd_r;
  assign out_starts_frame  = end_r;
  assign out_ends_frame    = end_r;
  assign out_polling       = polling_r;
  assign out_pad_bytes     = data_r;
  assign out_led_pattern_n = led_r;
  assign out_led_updated   = upd_r;

endmodule

### verif/gamepad_link_sequencer_top_tb.sv
// Testbench for gamepad_link_sequencer_top: set-up retries, polling and LED select checks.
`timescale 1ns / 1ps

module gamepad_link_sequencer_top_tb;

  localparam int NUM_DATA = int'(glseq_pkg::DATA_BYTES_DEF);

  typedef struct {
    logic [7:0]  cmd;
    logic        starts;
    logic        ends;
    logic        polling;
    logic [47:0] pad;
    logic [7:0]  led;
    logic        led_upd;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_reply_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_next_command;
  logic        out_starts_frame;
  logic        out_ends_frame;
  logic        out_polling;
  logic [47:0] out_pad_bytes;
  logic [7:0]  out_led_pattern_n;
  logic        out_led_updated;

  gamepad_link_sequencer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_reply_byte     (in_reply_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_command  (out_next_command),
    .out_starts_frame  (out_starts_frame),
    .out_ends_frame    (out_ends_frame),
    .out_polling       (out_polling),
    .out_pad_bytes     (out_pad_bytes),
    .out_led_pattern_n (out_led_pattern_n),
    .out_led_updated   (out_led_updated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // link state mirror
  glseq_pkg::frame_kind_t link_kind = glseq_pkg::KIND_ENTER;
  logic [3:0]  link_idx = 4'd0;
  logic [7:0]  tries = 8'd0;
  logic [7:0]  id_byte = 8'd0;
  logic [47:0] pad_store = 48'd0;
  logic [2:0]  led_sel = 3'd0;
  logic        sel_armed = 1'b0;
  logic [7:0]  led_now = glseq_pkg::LED_OFF;

  link_result_t pending_results[$];

  bit idle_on = 1'b1;
  bit rx_hold_req = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int setup_passes = 0;
  int poll_frames = 0;
  int led_changes = 0;
  int wait_cnt;

  function automatic logic [7:0] link_command(glseq_pkg::frame_kind_t k, logic [3:0] i);
    logic [7:0] c;
    c = glseq_pkg::CMD_IDLE;
    if (i == 4'd0) c = glseq_pkg::CMD_START;
    else if (i == 4'd1) begin
      case (k)
        glseq_pkg::KIND_ENTER, glseq_pkg::KIND_EXIT: c = glseq_pkg::CMD_ENTER;
        glseq_pkg::KIND_ANALOG:                      c = glseq_pkg::CMD_ANALOG;
        default:                                     c = glseq_pkg::CMD_POLL;
      endcase
    end else begin
      case (k)
        glseq_pkg::KIND_ENTER:
          c = (i == 4'd3) ? glseq_pkg::CMD_START : glseq_pkg::CMD_IDLE;
        glseq_pkg::KIND_ANALOG:
          c = (i == 4'd3) ? glseq_pkg::CMD_START :
              (i == 4'd4) ? glseq_pkg::CMD_LOCK : glseq_pkg::CMD_IDLE;
        glseq_pkg::KIND_EXIT:
          c = (i >= 4'd4 && i <= 4'd8) ? glseq_pkg::CMD_EXIT_PAD : glseq_pkg::CMD_IDLE;
        default: c = glseq_pkg::CMD_IDLE;
      endcase
    end
    return c;
  endfunction

  function automatic int frame_length(glseq_pkg::frame_kind_t k);
    if (k == glseq_pkg::KIND_ENTER) return 5;
    if (k == glseq_pkg::KIND_POLL) return 3 + NUM_DATA;
    return 9;
  endfunction

  function automatic void predict_link_step(logic [7:0] r);
    glseq_pkg::frame_kind_t k;
    int                     idx;
    bit                     fin;
    logic [7:0]             led_next;
    link_result_t           res;
    k = link_kind;
    idx = int'(link_idx);
    res.led_upd = 1'b0;
    if (k == glseq_pkg::KIND_CHECK && idx == 1) id_byte = r;
    if (k == glseq_pkg::KIND_POLL && idx >= 3 && idx - 3 < NUM_DATA)
      pad_store[8*(idx-3) +: 8] = r;
    fin = (idx + 1 >= frame_length(k));
    if (fin) begin
      led_next = led_now;
      case (k)
        glseq_pkg::KIND_CHECK: begin
          led_next = ~tries;
          tries = (tries >= glseq_pkg::ATTEMPT_MAX) ? 8'd0 : tries + 8'd1;
          k = (id_byte == glseq_pkg::ANALOG_ID) ? glseq_pkg::KIND_POLL : glseq_pkg::KIND_ENTER;
        end
        glseq_pkg::KIND_POLL: begin
          if (!pad_store[0] && !sel_armed) sel_armed = 1'b1;
          else if (pad_store[0] && sel_armed) begin
            led_sel = (led_sel + 1 >= NUM_DATA) ? 3'd0 : led_sel + 3'd1;
            sel_armed = 1'b0;
          end
          led_next = ~pad_store[8*led_sel +: 8];
        end
        default: k = glseq_pkg::frame_kind_t'(k + 3'd1);
      endcase
      res.led_upd = (led_next != led_now);
      led_now = led_next;
      link_idx = 4'd0;
    end else begin
      link_idx = link_idx + 4'd1;
    end
    link_kind = k;
    res.cmd = link_command(link_kind, link_idx);
    res.starts = fin;
    res.ends = fin;
    res.polling = (link_kind == glseq_pkg::KIND_POLL);
    res.pad = pad_store;
    res.led = led_now;
    pending_results.push_back(res);
  endfunction

  task automatic send_reply(input logic [7:0] b);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 15)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_reply_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_link_step(b);
  endtask

  // One set-up pass from the enter frame through the check frame.
  task automatic run_setup_pass(input logic [7:0] id, input bit use_fill, input logic [7:0] fill);
    bit was_check;
    logic [7:0] b;
    do begin
      was_check = (link_kind == glseq_pkg::KIND_CHECK);
      if (was_check && link_idx == 4'd1) b = id;
      else b = use_fill ? fill : 8'($urandom);
      send_reply(b);
    end while (!(was_check && link_idx == 4'd0));
    setup_passes++;
  endtask

  task automatic run_poll_frame(input logic [7:0] first_data);
    logic [7:0] b;
    for (int i = 0; i < 3 + NUM_DATA; i++) begin
      b = (i == 3) ? first_data : 8'($urandom);
      send_reply(b);
    end
    poll_frames++;
  endtask

  task automatic test_setup_retry();
    run_setup_pass(8'h00, 1'b1, 8'h00);
    run_setup_pass(8'hFF, 1'b1, 8'hFF);
    run_setup_pass(8'h72, 1'b0, 8'h00);
    run_setup_pass(8'hF3, 1'b0, 8'h00);
  endtask

  // Back-to-back failed passes with random mode replies.
  task automatic test_setup_failures();
    logic [7:0] id;
    idle_on = 1'b0;
    for (int p = 0; p < 2; p++) begin
      do id = 8'($urandom); while (id == glseq_pkg::ANALOG_ID);
      run_setup_pass(id, 1'b0, 8'h00);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_poll_entry();
    run_setup_pass(glseq_pkg::ANALOG_ID, 1'b0, 8'h00);
    run_poll_frame(8'hFF);
    run_poll_frame(8'h00);
  endtask

  task automatic test_select_button();
    for (int p = 0; p < 4; p++) begin
      run_poll_frame(8'hFE);
      if (p % 3 == 0) run_poll_frame(8'h02);
      run_poll_frame(8'h01);
      if (p % 2 == 0) run_poll_frame(8'hFF);
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_hold_req = 1'b1;
    run_poll_frame(8'($urandom));
    run_poll_frame(8'($urandom));
    idle_on = 1'b1;
  endtask

  task automatic test_random_polls();
    for (int f = 0; f < 4; f++) begin
      if (f == 1) idle_on = 1'b0;
      if (f == 3) idle_on = 1'b1;
      run_poll_frame(8'($urandom));
    end
    idle_on = 1'b1;
  endtask

  // receiver side
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      gap = idle_on ? int'($urandom_range(0, 15)) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    link_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word, next_command %0h", out_next_command);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("next_command", 48'(e.cmd), 48'(out_next_command));
        check_field("starts_frame", 48'(e.starts), 48'(out_starts_frame));
        check_field("ends_frame", 48'(e.ends), 48'(out_ends_frame));
        check_field("polling", 48'(e.polling), 48'(out_polling));
        check_field("pad_bytes", e.pad, out_pad_bytes);
        check_field("led_pattern_n", 48'(e.led), 48'(out_led_pattern_n));
        check_field("led_updated", 48'(e.led_upd), 48'(out_led_updated));
        if (e.led_upd) led_changes++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("gamepad_link_sequencer_top_tb failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_setup_retry();
    test_setup_failures();
    test_poll_entry();
    test_select_button();
    test_backpressure();
    test_random_polls();
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      errors++;
    end
    $display("covered %0d set-up passes with retries, %0d poll frames with select presses",
             setup_passes, poll_frames);
    $display("checked %0d result words, %0d LED changes, %0d errors", results_seen, led_changes,
             errors);
    if (errors == 0) begin
      $display("gamepad_link_sequencer_top_tb passed");
    end else begin
      $display("gamepad_link_sequencer_top_tb failed");
    end
    $finish;
  end

endmodule
